### rtl/led_duty_lightness_meter_assert.svh
// Assertion macros for the LED duty lightness meter.
// Included by the modules that check their own sequencing; no other dependencies.
`ifndef LED_DUTY_LIGHTNESS_METER_ASSERT_SVH
`define LED_DUTY_LIGHTNESS_METER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LDLM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ldlm check failed");
`define LDLM_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ldlm sequence check failed");
`else
`define LDLM_ASSERT(lbl, clk, rst, prop)
`define LDLM_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

### rtl/ldlm_pkg.sv
// Shared types and constants for the LED duty lightness meter.
// No dependencies.
package ldlm_pkg;

   localparam int NUM_LEDS  = 9;
   localparam int TIME_BITS = 48;
   localparam int IDX_BITS  = 4;
   localparam int L_BITS    = 16;
   localparam int CNT_BITS  = 5;
   localparam int NUM_BITS  = 23;  // numerator of the final constant divide
   localparam int RCP_BITS  = 55;  // numerator times reciprocal

   localparam logic [1:0] MODE_PIN   = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [L_BITS-1:0]    L_MAX      = 16'hFFFF;
   localparam logic [L_BITS-1:0]    Y_LIN_MAX  = 16'd580;
   localparam logic [13:0]          LIN_GAIN   = 14'd9033;
   localparam logic [9:0]           LIN_ROUND  = 10'd500;
   localparam logic [6:0]           CB_GAIN    = 7'd116;
   localparam logic [5:0]           CB_ROUND   = 6'd50;
   localparam logic [NUM_BITS-1:0]  CB_OFFSET  = 23'd1048576;

   // floor(n / 1000) = (n * ceil(2^38 / 1000)) >> 38, exact for any 32-bit n
   localparam logic [31:0]          LIN_RCP    = 32'h10624DD3;
   localparam int                   LIN_SHIFT  = 38;
   // floor(n / 100) = (n * ceil(2^37 / 100)) >> 37, exact for any 32-bit n
   localparam logic [31:0]          CB_RCP     = 32'h51EB851F;
   localparam int                   CB_SHIFT   = 37;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PIN_ADD,
      ST_Q_CHECK,
      ST_Q_DIFF,
      ST_Q_SUM,
      ST_Q_SPAN,
      ST_Q_TEST,
      ST_DIV,
      ST_CB_SQ,
      ST_CB_CUBE,
      ST_CB_SCALE,
      ST_DIVC,
      ST_STORE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clr_all;
      logic set_on;
      logic add_total;
      logic hist_clear;
      logic hist_store;
   } upd_type;

endpackage

### rtl/led_duty_lightness_meter.sv
// Top level of the LED duty lightness meter: state table, sequencer and shared datapath.
// Depends on ldlm_pkg and led_duty_lightness_meter_assert.svh.
//
//   channel | ports                                       | direction
//   req     | req_valid/ready, mode, led_index, pin_level, timestamp | in
//   rsp     | rsp_valid/ready, lightness, led_echo        | out
//   csr     | csr_valid/ready, csr_wdata (active_high_mask) | in
//
// Pin change and clear go from DECODE back to IDLE, by way of PIN_ADD when a pin
// change closes an active span; a repeat query goes from DECODE to DONE, and a
// query that saturates early from Q_CHECK or Q_TEST to STORE. A full query runs
// DECODE, Q_CHECK to Q_TEST, 16 divider steps, on the cube-root path the root on the
// shared multiplier and CB_SCALE, then DIVC unless that gives zero, store and output.
// Reset is synchronous and clears all accounting; req_ready is low while an item runs.
// A result waits in the output register; a stalled rsp holds the sequencer in DONE.
`include "led_duty_lightness_meter_assert.svh"
module led_duty_lightness_meter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_led_index,
   input  logic        req_pin_level,
   input  logic [47:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_lightness,
   output logic [3:0]  rsp_led_echo,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata
);

   localparam int N  = ldlm_pkg::NUM_LEDS;
   localparam int TB = ldlm_pkg::TIME_BITS;
   localparam int LB = ldlm_pkg::L_BITS;
   localparam int NB = ldlm_pkg::NUM_BITS;
   localparam int PB = ldlm_pkg::RCP_BITS;
   localparam int CB = ldlm_pkg::CNT_BITS;

   // per-LED accounting
   logic          led_on_ff  [N];
   logic [TB-1:0] on_since_ff[N];
   logic [TB-1:0] on_total_ff[N];
   logic [TB-1:0] taq_ff     [N];
   logic [TB-1:0] tmq_ff     [N];
   logic [LB-1:0] cache_ff   [N];

   ldlm_pkg::state_type state_ff, state_in;
   logic [N-1:0]  mask_ff;
   logic [1:0]    mode_ff, mode_in;
   logic [3:0]    idx_ff, idx_in;
   logic          level_ff, level_in;
   logic [TB-1:0] now_ff, now_in;
   logic [TB-1:0] acc_ff, acc_in;
   logic [TB-1:0] den_ff, den_in;
   logic [TB-1:0] rem_ff, rem_in;
   logic [LB-1:0] q_ff, q_in;
   logic [31:0]   sq_ff, sq_in;
   logic [15:0]   c_ff, c_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] num_ff, num_in;
   logic          dsel_ff, dsel_in;
   logic [LB-1:0] l_ff, l_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0] rsp_l_ff, rsp_l_in;
   logic [3:0]    rsp_led_ff, rsp_led_in;
   ldlm_pkg::upd_type upd;

   // entry read at the current index
   logic          e_on;
   logic [TB-1:0] e_since, e_total, e_taq, e_tmq;
   logic [LB-1:0] e_cache;
   logic          idx_ok;
   logic [TB:0]   div_sh, div_diff;
   logic [15:0]   trial;
   logic [31:0]   mul_a;
   logic [47:0]   mul_p;
   logic [NB-1:0] cb_num;
   logic [31:0]   rcp;
   logic [PB-1:0] rcp_p;
   logic [NB-1:0] rcp_q;

   assign idx_ok  = (idx_ff < 4'(N));
   assign e_on    = led_on_ff[idx_ff];
   assign e_since = on_since_ff[idx_ff];
   assign e_total = on_total_ff[idx_ff];
   assign e_taq   = taq_ff[idx_ff];
   assign e_tmq   = tmq_ff[idx_ff];
   assign e_cache = cache_ff[idx_ff];

   // shared datapath pieces
   assign div_sh   = {rem_ff, 1'b0};
   assign div_diff = div_sh - {1'b0, den_ff};
   assign trial    = c_ff | (16'd1 << cnt_ff[3:0]);
   // one multiplier: trial squared, then square times trial
   assign mul_a    = (state_ff == ldlm_pkg::ST_CB_SQ) ? {16'd0, trial} : sq_ff;
   assign mul_p    = 48'(mul_a) * 48'(trial);
   assign cb_num   = NB'(ldlm_pkg::CB_GAIN) * NB'(c_ff) + NB'(ldlm_pkg::CB_ROUND);
   // constant divide by reciprocal multiply
   assign rcp      = dsel_ff ? ldlm_pkg::LIN_RCP : ldlm_pkg::CB_RCP;
   assign rcp_p    = PB'(num_ff) * PB'(rcp);
   assign rcp_q    = dsel_ff ? NB'(rcp_p >> ldlm_pkg::LIN_SHIFT)
                             : NB'(rcp_p >> ldlm_pkg::CB_SHIFT);

   assign req_ready     = (state_ff == ldlm_pkg::ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lightness = rsp_l_ff;
   assign rsp_led_echo  = rsp_led_ff;

   // sequencer: next state, datapath next values, table updates
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; idx_in = idx_ff; level_in = level_ff; now_in = now_ff;
      acc_in = acc_ff; den_in = den_ff; rem_in = rem_ff; q_in = q_ff;
      sq_in = sq_ff; c_in = c_ff; cnt_in = cnt_ff; num_in = num_ff;
      dsel_in = dsel_ff; l_in = l_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_l_in = rsp_l_ff; rsp_led_in = rsp_led_ff;
      upd = '0;
      unique case (state_ff)
         ldlm_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               idx_in   = req_led_index;
               level_in = req_pin_level;
               now_in   = req_timestamp;
               state_in = ldlm_pkg::ST_DECODE;
            end
         end
         ldlm_pkg::ST_DECODE: begin
            state_in = ldlm_pkg::ST_IDLE;
            if (mode_ff == ldlm_pkg::MODE_CLEAR) begin
               upd.clr_all = 1'b1;
            end else if (idx_ok && mode_ff == ldlm_pkg::MODE_PIN) begin
               if (e_on != (level_ff == mask_ff[idx_ff])) begin
                  if (!e_on) begin
                     upd.set_on = 1'b1;
                  end else begin
                     acc_in   = now_ff - e_since;
                     state_in = ldlm_pkg::ST_PIN_ADD;
                  end
               end
            end else if (idx_ok && mode_ff == ldlm_pkg::MODE_QUERY) begin
               if (now_ff == e_tmq) begin
                  l_in     = e_cache;
                  state_in = ldlm_pkg::ST_DONE;
               end else begin
                  upd.hist_clear = (now_ff < e_tmq);
                  state_in       = ldlm_pkg::ST_Q_CHECK;
               end
            end
         end
         ldlm_pkg::ST_PIN_ADD: begin
            upd.add_total = 1'b1;
            state_in      = ldlm_pkg::ST_IDLE;
         end
         ldlm_pkg::ST_Q_CHECK: begin
            if (e_on && e_since < e_tmq) begin
               l_in     = ldlm_pkg::L_MAX;
               state_in = ldlm_pkg::ST_STORE;
            end else begin
               acc_in   = e_total - e_taq;
               state_in = ldlm_pkg::ST_Q_DIFF;
            end
         end
         ldlm_pkg::ST_Q_DIFF: begin
            rem_in   = e_on ? now_ff - e_since : '0;
            state_in = ldlm_pkg::ST_Q_SUM;
         end
         ldlm_pkg::ST_Q_SUM: begin
            acc_in   = acc_ff + rem_ff;
            state_in = ldlm_pkg::ST_Q_SPAN;
         end
         ldlm_pkg::ST_Q_SPAN: begin
            den_in   = now_ff - e_tmq;
            state_in = ldlm_pkg::ST_Q_TEST;
         end
         ldlm_pkg::ST_Q_TEST: begin
            if (den_ff == '0 || acc_ff >= den_ff) begin
               l_in     = ldlm_pkg::L_MAX;
               state_in = ldlm_pkg::ST_STORE;
            end else begin
               rem_in   = acc_ff;
               q_in     = '0;
               cnt_in   = '0;
               state_in = ldlm_pkg::ST_DIV;
            end
         end
         // one quotient bit a cycle
         ldlm_pkg::ST_DIV: begin
            if (!div_diff[TB]) begin
               rem_in = div_diff[TB-1:0];
               q_in   = {q_ff[LB-2:0], 1'b1};
            end else begin
               rem_in = div_sh[TB-1:0];
               q_in   = {q_ff[LB-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CB'(LB - 1)) begin
               if (q_in <= ldlm_pkg::Y_LIN_MAX) begin
                  num_in   = NB'(ldlm_pkg::LIN_GAIN) * NB'(q_in)
                             + NB'(ldlm_pkg::LIN_ROUND);
                  dsel_in  = 1'b1;
                  state_in = ldlm_pkg::ST_DIVC;
               end else begin
                  c_in     = '0;
                  cnt_in   = CB'(15);
                  state_in = ldlm_pkg::ST_CB_SQ;
               end
            end
         end
         // cube root, one bit per CB_SQ and CB_CUBE pass on the shared multiplier
         ldlm_pkg::ST_CB_SQ: begin
            sq_in    = mul_p[31:0];
            state_in = ldlm_pkg::ST_CB_CUBE;
         end
         ldlm_pkg::ST_CB_CUBE: begin
            if (mul_p <= {q_ff, 32'd0}) c_in = trial;
            if (cnt_ff == '0) begin
               state_in = ldlm_pkg::ST_CB_SCALE;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = ldlm_pkg::ST_CB_SQ;
            end
         end
         ldlm_pkg::ST_CB_SCALE: begin
            if (cb_num < ldlm_pkg::CB_OFFSET) begin
               l_in     = '0;
               state_in = ldlm_pkg::ST_STORE;
            end else begin
               num_in   = cb_num - ldlm_pkg::CB_OFFSET;
               dsel_in  = 1'b0;
               state_in = ldlm_pkg::ST_DIVC;
            end
         end
         // divide by the constant and limit to full scale
         ldlm_pkg::ST_DIVC: begin
            l_in     = (rcp_q > NB'(ldlm_pkg::L_MAX)) ? ldlm_pkg::L_MAX : rcp_q[LB-1:0];
            state_in = ldlm_pkg::ST_STORE;
         end
         ldlm_pkg::ST_STORE: begin
            upd.hist_store = 1'b1;
            state_in       = ldlm_pkg::ST_DONE;
         end
         ldlm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = l_ff;
               rsp_led_in   = idx_ff;
               state_in     = ldlm_pkg::ST_IDLE;
            end
         end
         default: state_in = ldlm_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ldlm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) mask_ff <= csr_wdata;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in; idx_ff <= idx_in; level_ff <= level_in; now_ff <= now_in;
      acc_ff <= acc_in; den_ff <= den_in; rem_ff <= rem_in; q_ff <= q_in;
      sq_ff <= sq_in; c_ff <= c_in; cnt_ff <= cnt_in; num_ff <= num_in;
      dsel_ff <= dsel_in; l_ff <= l_in;
      rsp_l_ff <= rsp_l_in; rsp_led_ff <= rsp_led_in;
   end

   // accounting table
   always_ff @(posedge clock) begin
      if (reset || upd.clr_all) begin
         for (int i = 0; i < N; i++) begin
            led_on_ff[i]   <= 1'b0;
            on_since_ff[i] <= '0;
            on_total_ff[i] <= '0;
         end
      end else if (upd.set_on) begin
         led_on_ff[idx_ff]   <= 1'b1;
         on_since_ff[idx_ff] <= now_ff;
      end else if (upd.add_total) begin
         led_on_ff[idx_ff]   <= 1'b0;
         on_total_ff[idx_ff] <= e_total + acc_ff;
      end
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            taq_ff[i]   <= '0;
            tmq_ff[i]   <= '0;
            cache_ff[i] <= '0;
         end
      end else if (upd.hist_clear) begin
         taq_ff[idx_ff]   <= '0;
         tmq_ff[idx_ff]   <= '0;
         cache_ff[idx_ff] <= '0;
      end else if (upd.hist_store) begin
         taq_ff[idx_ff]   <= e_total;
         tmq_ff[idx_ff]   <= now_ff;
         cache_ff[idx_ff] <= l_ff;
      end
   end

   `LDLM_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready,
                     state_ff == ldlm_pkg::ST_DECODE)
   `LDLM_ASSERT(a_done_is_query, clock, reset,
                state_ff == ldlm_pkg::ST_DONE |-> mode_ff == ldlm_pkg::MODE_QUERY && idx_ok)
   `LDLM_ASSERT(a_div_count, clock, reset,
                state_ff == ldlm_pkg::ST_DIV |-> cnt_ff < CB'(LB))
   `LDLM_ASSERT_NEXT(a_rsp_from_done, clock, reset,
                     !rsp_valid && state_ff != ldlm_pkg::ST_DONE, !rsp_valid)

endmodule

### tb/testbench.sv
// Self-checking testbench for the LED duty lightness meter: drives pin changes, queries
// and clears, predicts lightness results and checks them. Depends on ldlm_pkg and the RTL.
`timescale 1ns / 1ps

class lightness_board;
   logic [15:0] pending_l[$];
   logic [3:0]  pending_led[$];
   int          errors = 0;

   function void note_query(logic [15:0] l, logic [3:0] led);
      pending_l.push_back(l);
      pending_led.push_back(led);
   endfunction

   function void check_beat(logic [15:0] l, logic [3:0] led);
      logic [15:0] el;
      logic [3:0]  eled;
      if (pending_l.size() == 0) begin
         $display("%0t: unexpected result lightness=%0d led=%0d", $time, l, led);
         errors++;
         return;
      end
      el = pending_l.pop_front();
      eled = pending_led.pop_front();
      if (l !== el) begin
         $display("%0t: lightness expected %0d actual %0d", $time, el, l);
         errors++;
      end
      if (led !== eled) begin
         $display("%0t: led_echo expected %0d actual %0d", $time, eled, led);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_l.size();
   endfunction
endclass

module testbench;

   localparam int WATCHDOG = 20000;
   localparam int NLED = ldlm_pkg::NUM_LEDS;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_mode = ldlm_pkg::MODE_PIN;
   logic [3:0]  req_led_index = '0;
   logic        req_pin_level = 0;
   logic [47:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_lightness;
   logic [3:0]  rsp_led_echo;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [8:0]  csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;
   logic [47:0] clock_now = '0;

   // predictor state
   logic [8:0]  polarity;
   logic        active[NLED];
   logic [47:0] active_since[NLED];
   logic [47:0] active_total[NLED];
   logic [47:0] total_seen[NLED];
   logic [47:0] last_query[NLED];
   logic [15:0] last_l[NLED];

   lightness_board board = new();

   led_duty_lightness_meter DUT (.*);

   always #10 clock = ~clock;

   function automatic logic [15:0] frac_q16(logic [47:0] t, logic [47:0] d);
      logic [48:0] r;
      logic [15:0] q;
      r = {1'b0, t};
      q = '0;
      for (int k = 0; k < 16; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [15:0] perceived(logic [15:0] yq);
      logic [63:0] x, c, tr, num, l;
      if (yq <= 16'd580) return 16'((32'd9033 * 32'(yq) + 32'd500) / 32'd1000);
      x = {16'd0, yq, 32'd0};
      c = '0;
      for (int b = 15; b >= 0; b--) begin
         tr = c | (64'd1 << b);
         if (tr * tr * tr <= x) c = tr;
      end
      num = 64'd116 * c + 64'd50;
      if (num < 64'd1048576) return 16'd0;
      l = (num - 64'd1048576) / 64'd100;
      return (l > 64'd65535) ? 16'hFFFF : l[15:0];
   endfunction

   // Update the predicted state for one accepted item; note a result if it gives one.
   function automatic void predict_item(logic [1:0] m, logic [3:0] i, logic p,
                                        logic [47:0] now);
      logic act;
      logic [47:0] t, d;
      logic [15:0] l;
      if (m == ldlm_pkg::MODE_CLEAR) begin
         for (int k = 0; k < NLED; k++) begin
            active[k] = 0; active_since[k] = '0; active_total[k] = '0;
         end
         return;
      end
      if (m == MODE_UNUSED || i >= 4'(NLED)) return;
      if (m == ldlm_pkg::MODE_PIN) begin
         act = (p == polarity[i]);
         if (active[i] != act) begin
            if (act) active_since[i] = now;
            else active_total[i] = active_total[i] + now - active_since[i];
            active[i] = act;
         end
         return;
      end
      if (now == last_query[i]) begin
         l = last_l[i];
      end else begin
         if (now < last_query[i]) begin
            total_seen[i] = '0; last_query[i] = '0; last_l[i] = '0;
         end
         l = 16'hFFFF;
         if (!active[i] || active_since[i] >= last_query[i]) begin
            t = active_total[i] - total_seen[i];
            d = now - last_query[i];
            if (active[i]) t = t + now - active_since[i];
            if (d != '0 && t < d) l = perceived(frac_q16(t, d));
         end
         total_seen[i] = active_total[i];
         last_query[i] = now;
         last_l[i] = l;
      end
      board.note_query(l, i);
   endfunction

   // Send one item and predict it at acceptance; valid is left high on return.
   task automatic send_item(logic [1:0] m, logic [3:0] i, logic p, logic [47:0] ts);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_mode <= m; req_led_index <= i;
      req_pin_level <= p; req_timestamp <= ts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(m, i, p, ts);
   endtask

   task automatic write_polarity(logic [8:0] mask);
      @(negedge clock);
      csr_valid <= 1; csr_wdata <= mask;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      polarity = mask;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Drop valid and hold until every expected result has come.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Mostly advancing time, with occasional repeats, random jumps and jumps back.
   function automatic logic [47:0] next_time();
      int r;
      r = $urandom_range(99);
      if (r < 5) return clock_now;
      if (r < 8) clock_now = 48'({$urandom, $urandom});
      else if (r < 10) clock_now = clock_now - 48'($urandom_range(5000));
      else clock_now = clock_now + 48'($urandom_range(r < 90 ? 200 : 100000));
      return clock_now;
   endfunction

   task automatic random_phase(int n);
      int r;
      logic [1:0] m;
      logic [3:0] i;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         m = (r < 55) ? ldlm_pkg::MODE_PIN : (r < 93) ? ldlm_pkg::MODE_QUERY :
             (r < 96) ? ldlm_pkg::MODE_CLEAR : MODE_UNUSED;
         i = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
         send_item(m, i, 1'($urandom), next_time());
         if (k == n / 2) drain();
      end
   endtask

   // Receiver: stall at random, check each result beat.
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_beat(rsp_lightness, rsp_led_echo);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("[led_duty_lightness_meter] ERROR");
         $finish;
      end
   end

   initial begin
      polarity = '0;
      for (int k = 0; k < NLED; k++) begin
         active[k] = 0; active_since[k] = '0; active_total[k] = '0;
         total_seen[k] = '0; last_query[k] = '0; last_l[k] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: default polarity, extremes, every mode
      send_item(ldlm_pkg::MODE_QUERY, 4'd0, 1'b0, 48'd0);     // same time as reset history
      send_item(ldlm_pkg::MODE_PIN, 4'd0, 1'b0, 48'd100);     // active low on
      send_item(ldlm_pkg::MODE_PIN, 4'd0, 1'b0, 48'd150);     // no state change
      send_item(ldlm_pkg::MODE_QUERY, 4'd0, 1'b0, 48'd200);   // active since before query
      send_item(ldlm_pkg::MODE_QUERY, 4'd0, 1'b0, 48'd200);   // repeat query
      send_item(ldlm_pkg::MODE_PIN, 4'd0, 1'b1, 48'd300);
      send_item(ldlm_pkg::MODE_QUERY, 4'd0, 1'b0, 48'd1300);  // small fraction
      send_item(ldlm_pkg::MODE_QUERY, 4'd0, 1'b0, 48'd100);   // earlier time
      send_item(ldlm_pkg::MODE_PIN, 4'd8, 1'b1, 48'hFFFF_FFFF_FFF0);
      send_item(ldlm_pkg::MODE_QUERY, 4'd8, 1'b0, 48'hFFFF_FFFF_FFFF);
      send_item(ldlm_pkg::MODE_QUERY, 4'd15, 1'b1, 48'd5);    // out of range
      send_item(MODE_UNUSED, 4'd3, 1'b1, 48'd7);              // unused mode
      send_item(ldlm_pkg::MODE_PIN, 4'd4, 1'b0, 48'd10);
      send_item(ldlm_pkg::MODE_CLEAR, 4'd0, 1'b0, 48'd20);
      send_item(ldlm_pkg::MODE_QUERY, 4'd4, 1'b0, 48'd30);
      send_item(ldlm_pkg::MODE_PIN, 4'd5, 1'b0, 48'd1000);
      send_item(ldlm_pkg::MODE_PIN, 4'd5, 1'b1, 48'd1001);
      send_item(ldlm_pkg::MODE_QUERY, 4'd5, 1'b0, 48'd1000000);  // linear region
      send_item(ldlm_pkg::MODE_PIN, 4'd5, 1'b0, 48'd1000000);
      send_item(ldlm_pkg::MODE_PIN, 4'd5, 1'b1, 48'd1500000);
      send_item(ldlm_pkg::MODE_QUERY, 4'd5, 1'b0, 48'd2000000);  // half on
      drain();

      write_polarity(9'h1FF);
      send_idle_pct = 16; recv_idle_pct = 51;
      random_phase(450);
      drain();
      write_polarity(9'h0A5);
      send_idle_pct = 51; recv_idle_pct = 16;
      random_phase(450);
      drain();
      write_polarity(9'h000);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(450);
      drain();

      if (board.errors == 0 && board.outstanding() == 0)
         $display("[led_duty_lightness_meter] OK");
      else
         $display("[led_duty_lightness_meter] ERROR");
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/ldlm_pkg.sv
rtl/led_duty_lightness_meter.sv
tb/testbench.sv
